@@ rtl/core/hue_rotation_hsv_to_rgb_macros.svh @@
// Assertion macros used by the top level of the colour engine RTL.
`ifndef HUE_ROTATION_HSV_TO_RGB_MACROS_SVH
`define HUE_ROTATION_HSV_TO_RGB_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HRH_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HRH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/hrh_pkg.sv @@
// Package of the colour engine: widths, constants, codes and shared types.
package hrh_pkg;

    localparam int HUE_W      = 9;
    localparam int PCT_W      = 7;
    localparam int RAMP_W     = 16;
    localparam int CHAN_W     = 8;
    localparam int M_W        = 15;
    localparam int K_W        = 13;
    localparam int ACC_W      = 28;
    localparam int CNT_W      = 4;
    localparam int NUM_LANES  = 4;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;
    localparam logic [HUE_W-1:0] HUE_STEP  = 9'd10;
    localparam logic [HUE_W-1:0] HUE_PIVOT = 9'd180;
    localparam logic [HUE_W-1:0] HUE_WRAP  = HUE_FULL - HUE_STEP;

    localparam logic [HUE_W-1:0] SEC_EDGE_1 = 9'd60;
    localparam logic [HUE_W-1:0] SEC_EDGE_2 = 9'd120;
    localparam logic [HUE_W-1:0] SEC_EDGE_3 = 9'd180;
    localparam logic [HUE_W-1:0] SEC_EDGE_4 = 9'd240;
    localparam logic [HUE_W-1:0] SEC_EDGE_5 = 9'd300;
    localparam logic [5:0]       SECTOR_DEG = 6'd60;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [K_W-1:0]   K_FULL   = 13'd6000;
    // Divisor 600000 (60 * 100 * 100) aligned to the top quotient bit.
    localparam logic [ACC_W-1:0] DIV_TOP  = 28'd76800000;

    localparam logic [CNT_W-1:0] MUL_LAST = 4'd12;
    localparam logic [CNT_W-1:0] DIV_LAST = 4'd7;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP = 2'd2;

    localparam int LANE_VV = 0;
    localparam int LANE_P  = 1;
    localparam int LANE_Q  = 2;
    localparam int LANE_T  = 3;

    typedef enum logic [2:0] {
        SEC_R_TO_Y,
        SEC_Y_TO_G,
        SEC_G_TO_C,
        SEC_C_TO_B,
        SEC_B_TO_M,
        SEC_M_TO_R
    } sector_t;

    typedef struct packed {
        sector_t                          sector;
        logic [M_W-1:0]                   m;
        logic [NUM_LANES-1:0][K_W-1:0]    k;
    } coef_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div;
    } lane_ctrl_t;

endpackage

@@ rtl/core/hrh_coef.sv @@
// Coefficient stage: hue sector, clamped percentages and the four channel multipliers.
module hrh_coef
    import hrh_pkg::*;
(
    input  logic [HUE_W-1:0] hue,
    input  logic [PCT_W-1:0] sat,
    input  logic [PCT_W-1:0] val,
    output coef_t            coef
);

    logic [PCT_W-1:0] s;
    logic [PCT_W-1:0] v_c;
    logic [PCT_W-1:0] v;
    logic [HUE_W-1:0] base;
    sector_t          sec;
    logic [5:0]       r;
    logic [5:0]       r_inv;
    logic [K_W-1:0]   rs;
    logic [K_W-1:0]   rs_inv;
    logic [K_W-1:0]   kp;

    always_comb
    begin
        s   = (sat > PCT_FULL) ? PCT_FULL : sat;
        v_c = (val > PCT_FULL) ? PCT_FULL : val;
        // A zero value reads as full brightness.
        v   = (v_c == '0) ? PCT_FULL : v_c;

        priority if (hue >= SEC_EDGE_5)
        begin
            sec  = SEC_M_TO_R;
            base = SEC_EDGE_5;
        end
        else if (hue >= SEC_EDGE_4)
        begin
            sec  = SEC_B_TO_M;
            base = SEC_EDGE_4;
        end
        else if (hue >= SEC_EDGE_3)
        begin
            sec  = SEC_C_TO_B;
            base = SEC_EDGE_3;
        end
        else if (hue >= SEC_EDGE_2)
        begin
            sec  = SEC_G_TO_C;
            base = SEC_EDGE_2;
        end
        else if (hue >= SEC_EDGE_1)
        begin
            sec  = SEC_Y_TO_G;
            base = SEC_EDGE_1;
        end
        else
        begin
            sec  = SEC_R_TO_Y;
            base = '0;
        end

        r      = 6'(hue - base);
        r_inv  = SECTOR_DEG - r;
        rs     = K_W'(r) * K_W'(s);
        rs_inv = K_W'(r_inv) * K_W'(s);
        kp     = K_W'(PCT_FULL - s) * K_W'(SECTOR_DEG);

        // All channels share the denominator 600000, so each gets a numerator factor.
        coef.sector     = sec;
        coef.m          = {v, {CHAN_W{1'b0}}} - M_W'(v);
        coef.k[LANE_VV] = K_FULL;
        coef.k[LANE_P]  = kp;
        coef.k[LANE_Q]  = K_FULL - rs;
        coef.k[LANE_T]  = K_FULL - rs_inv;
    end

endmodule

@@ rtl/core/hrh_lane.sv @@
// Bit-serial lane: shift-add multiply then restoring division by 600000.
module hrh_lane
    import hrh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lane_ctrl_t        ctrl,
    input  logic [M_W-1:0]    m,
    input  logic [K_W-1:0]    k,
    output logic [CHAN_W-1:0] q
);

    logic [M_W-1:0]    m_reg;
    logic [M_W-1:0]    m_next;
    logic [K_W-1:0]    k_reg;
    logic [K_W-1:0]    k_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [CHAN_W-1:0] q_reg;
    logic [CHAN_W-1:0] q_next;
    logic [ACC_W-1:0]  diff;

    always_comb
    begin
        m_next   = m_reg;
        k_next   = k_reg;
        acc_next = acc_reg;
        q_next   = q_reg;
        diff     = acc_reg - DIV_TOP;
        if (ctrl.load)
        begin
            m_next   = m;
            k_next   = k;
            acc_next = '0;
            q_next   = '0;
        end
        else if (ctrl.mul)
        begin
            // Multiplier bits enter from the top, one per cycle.
            acc_next = {acc_reg[ACC_W-2:0], 1'b0}
                     + (k_reg[K_W-1] ? ACC_W'(m_reg) : '0);
            k_next   = {k_reg[K_W-2:0], 1'b0};
        end
        else if (ctrl.div)
        begin
            // The remainder stays below twice the aligned divisor, so one compare suffices.
            if (acc_reg >= DIV_TOP)
            begin
                acc_next = {diff[ACC_W-2:0], 1'b0};
                q_next   = {q_reg[CHAN_W-2:0], 1'b1};
            end
            else
            begin
                acc_next = {acc_reg[ACC_W-2:0], 1'b0};
                q_next   = {q_reg[CHAN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg   <= '0;
            k_reg   <= '0;
            acc_reg <= '0;
            q_reg   <= '0;
        end
        else
        begin
            m_reg   <= m_next;
            k_reg   <= k_next;
            acc_reg <= acc_next;
            q_reg   <= q_next;
        end
    end

    assign q = q_reg;

endmodule

@@ rtl/core/hue_rotation_hsv_to_rgb.sv @@
// Top level of the hue-cycling colour engine with HSV to RGB conversion.
//
// Input beats arrive on s_axis: tuser carries the operation (start or tick) and
// tdata the start hue in degrees. A start beat sets the fade direction from its
// hue and yields that hue's colour with a ramp time of zero. A tick beat steps the
// running hue by ten degrees up or down, wrapping at 360, and yields its colour
// with the configured ramp period. A tick before any start yields no beat.
// Result beats leave on m_axis carrying red, green, blue, ramp_ms and shown_hue.
// The cfg port writes saturation, value and ramp period; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Each item passes through the states S_IDLE, in which the beat is accepted,
// S_SETUP, in which the lanes load the coefficients, S_MUL for the bit-serial
// multiply, S_DIV for the bit-serial divide by 600000 and S_DONE, which loads
// the output register. The result appears there as the block returns to S_IDLE,
// ready for the next beat. A tick before any start is taken and dropped while
// the block stays idle. The output register parts the two sides, so a new beat
// is taken while a result waits; a finished item holds in its last step until
// that register is free.
// Reset clears the fade state and loads saturation and value with 100 and the
// ramp period with zero; no result is pending afterwards.
module hue_rotation_hsv_to_rgb
    import hrh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [8:0] hue
    input  logic                  s_axis_tuser,   // [0] op
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [39:24] ramp_ms, [48:40] shown_hue
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "hue_rotation_hsv_to_rgb_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    localparam int PAD_W = OUT_DATA_W - 3 * CHAN_W - RAMP_W - HUE_W;

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [PCT_W-1:0]      sat_reg;
    logic [PCT_W-1:0]      val_reg;
    logic [RAMP_W-1:0]     ramp_reg;
    logic [HUE_W-1:0]      running_hue_reg;
    logic [HUE_W-1:0]      running_hue_next;
    logic                  rotate_up_reg;
    logic                  rotate_up_next;
    logic                  started_reg;
    logic                  started_next;
    logic [HUE_W-1:0]      conv_hue_reg;
    logic [HUE_W-1:0]      conv_hue_next;
    logic [RAMP_W-1:0]     conv_ramp_reg;
    logic [RAMP_W-1:0]     conv_ramp_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic                  accept;
    logic                  early_tick;
    logic [HUE_W-1:0]      in_hue;
    logic [HUE_W-1:0]      start_hue;
    logic [HUE_W-1:0]      step_hue;
    coef_t                 coef;
    lane_ctrl_t            lane_ctrl;
    logic [NUM_LANES-1:0][CHAN_W-1:0] lane_q;
    logic [CHAN_W-1:0]     red;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     blue;

    hrh_coef u_coef
    (
        .hue  (conv_hue_reg),
        .sat  (sat_reg),
        .val  (val_reg),
        .coef (coef)
    );

    assign lane_ctrl.load = (state_reg == S_SETUP);
    assign lane_ctrl.mul  = (state_reg == S_MUL);
    assign lane_ctrl.div  = (state_reg == S_DIV);

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        hrh_lane u_lane
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl),
            .m     (coef.m),
            .k     (coef.k[i]),
            .q     (lane_q[i])
        );
    end

    // Configuration registers; an unused index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg  <= PCT_FULL;
            val_reg  <= PCT_FULL;
            ramp_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_SAT)
            begin
                sat_reg <= cfg_data[PCT_W-1:0];
            end
            if (cfg_index == REG_VAL)
            begin
                val_reg <= cfg_data[PCT_W-1:0];
            end
            if (cfg_index == REG_RAMP)
            begin
                ramp_reg <= cfg_data[RAMP_W-1:0];
            end
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign early_tick    = accept && (s_axis_tuser == OP_TICK) && !started_reg;
    assign in_hue        = s_axis_tdata[HUE_W-1:0];

    always_comb
    begin
        // Out-of-range start hues are folded back into one turn.
        start_hue = (in_hue >= HUE_FULL) ? (in_hue - HUE_FULL) : in_hue;
        if (rotate_up_reg)
        begin
            step_hue = (running_hue_reg >= HUE_WRAP) ? (running_hue_reg - HUE_WRAP)
                                                     : (running_hue_reg + HUE_STEP);
        end
        else
        begin
            step_hue = (running_hue_reg < HUE_STEP) ? (running_hue_reg + HUE_WRAP)
                                                    : (running_hue_reg - HUE_STEP);
        end
    end

    // Channel routing per hue sector.
    always_comb
    begin
        unique case (coef.sector)
            SEC_R_TO_Y:
            begin
                red = lane_q[LANE_VV]; green = lane_q[LANE_T]; blue = lane_q[LANE_P];
            end
            SEC_Y_TO_G:
            begin
                red = lane_q[LANE_Q]; green = lane_q[LANE_VV]; blue = lane_q[LANE_P];
            end
            SEC_G_TO_C:
            begin
                red = lane_q[LANE_P]; green = lane_q[LANE_VV]; blue = lane_q[LANE_T];
            end
            SEC_C_TO_B:
            begin
                red = lane_q[LANE_P]; green = lane_q[LANE_Q]; blue = lane_q[LANE_VV];
            end
            SEC_B_TO_M:
            begin
                red = lane_q[LANE_T]; green = lane_q[LANE_P]; blue = lane_q[LANE_VV];
            end
            default:
            begin
                red = lane_q[LANE_VV]; green = lane_q[LANE_P]; blue = lane_q[LANE_Q];
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        running_hue_next = running_hue_reg;
        rotate_up_next   = rotate_up_reg;
        started_next     = started_reg;
        conv_hue_next    = conv_hue_reg;
        conv_ramp_next   = conv_ramp_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == OP_START)
                    begin
                        // A start keeps the running hue and shows its own hue.
                        rotate_up_next = (start_hue > HUE_PIVOT);
                        started_next   = 1'b1;
                        conv_hue_next  = start_hue;
                        conv_ramp_next = '0;
                        state_next     = S_SETUP;
                    end
                    else if (started_reg)
                    begin
                        running_hue_next = step_hue;
                        conv_hue_next    = step_hue;
                        conv_ramp_next   = ramp_reg;
                        state_next       = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{PAD_W{1'b0}}, conv_hue_reg, conv_ramp_reg,
                                      blue, green, red};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            running_hue_reg <= '0;
            rotate_up_reg   <= 1'b0;
            started_reg     <= 1'b0;
            conv_hue_reg    <= '0;
            conv_ramp_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            running_hue_reg <= running_hue_next;
            rotate_up_reg   <= rotate_up_next;
            started_reg     <= started_next;
            conv_hue_reg    <= conv_hue_next;
            conv_ramp_reg   <= conv_ramp_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A tick taken before any start leaves the block idle.
    `HRH_ASSERT_NEXT(a_early_tick_idle, early_tick, state_reg == S_IDLE, "early tick started work")
    // Once started, the fade stays started.
    `HRH_ASSERT_NEXT(a_started_sticky, started_reg, started_reg, "started flag cleared")
    // The running hue stays within one turn.
    `HRH_ASSERT_IMPL(a_hue_range, 1'b1, running_hue_reg < HUE_FULL, "running hue out of range")
    // A result appears only out of the final step.
    `HRH_ASSERT_IMPL(a_valid_source, $rose(out_valid_reg), $past(state_reg == S_DONE), "stray result")

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the hue-cycling HSV to RGB colour engine.
module testbench;
    import hrh_pkg::*;

    // The block decodes two bits of register index but holds only three registers;
    // a write to the fourth index must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // A pause of SETTLE_CYCLES after the last result outlasts a beat's work inside
    // the block, so any tick that produced nothing has finished by its end.
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_ITEMS  = 650;
    localparam int PHASE_ITEMS   = 130;

    // One result beat, laid out as on m_axis_tdata with red in the lowest bits.
    typedef struct packed {
        logic [HUE_W-1:0]  shown_hue;
        logic [RAMP_W-1:0] ramp_ms;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } colour_t;

    // Receiver behaviour: always ready, coin toss, rarely ready, or a fixed comb.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_COMB
    } rx_mode_t;

    // Tracks the fade state and the registers as the block should hold them, and
    // keeps the colours that are still owed on the output side, oldest first.
    class hue_colour_tracker;
        logic [PCT_W-1:0]  saturation;
        logic [PCT_W-1:0]  value;
        logic [RAMP_W-1:0] ramp_period;
        logic [HUE_W-1:0]  running_hue;
        logic              rotate_up;
        logic              started;
        colour_t           colour_due[$];
        int                errors;

        function new();
            saturation  = PCT_FULL;
            value       = PCT_FULL;
            ramp_period = '0;
            running_hue = '0;
            rotate_up   = 1'b0;
            started     = 1'b0;
            errors      = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            unique case (index)
                REG_SAT:  saturation  = data[PCT_W-1:0];
                REG_VAL:  value       = data[PCT_W-1:0];
                REG_RAMP: ramp_period = data[RAMP_W-1:0];
                default:  ;
            endcase
        endfunction

        // Colour of a hue below 360 under the present saturation and value.
        // All channels are exact integer ratios truncated toward zero.
        function colour_t shade_of(logic [HUE_W-1:0] hue, logic [RAMP_W-1:0] ramp);
            int unsigned s, v, r, vv, p, q, t;
            colour_t     c;
            s = (saturation > PCT_FULL) ? PCT_FULL : saturation;
            v = (value > PCT_FULL) ? PCT_FULL : value;
            if (v == 0)
                v = PCT_FULL;
            r  = hue % SECTOR_DEG;
            vv = 255 * v / 100;
            p  = 255 * v * (100 - s) / 10000;
            q  = 255 * v * (6000 - r * s) / 600000;
            t  = 255 * v * (6000 - (60 - r) * s) / 600000;
            c.ramp_ms   = ramp;
            c.shown_hue = hue;
            unique case (sector_t'(3'(hue / SECTOR_DEG)))
                SEC_R_TO_Y:
                begin
                    c.red = 8'(vv); c.green = 8'(t);  c.blue = 8'(p);
                end
                SEC_Y_TO_G:
                begin
                    c.red = 8'(q);  c.green = 8'(vv); c.blue = 8'(p);
                end
                SEC_G_TO_C:
                begin
                    c.red = 8'(p);  c.green = 8'(vv); c.blue = 8'(t);
                end
                SEC_C_TO_B:
                begin
                    c.red = 8'(p);  c.green = 8'(q);  c.blue = 8'(vv);
                end
                SEC_B_TO_M:
                begin
                    c.red = 8'(t);  c.green = 8'(p);  c.blue = 8'(vv);
                end
                default:
                begin
                    c.red = 8'(vv); c.green = 8'(p);  c.blue = 8'(q);
                end
            endcase
            return c;
        endfunction

        // Called for every accepted input beat.
        function void note_item(logic op, logic [HUE_W-1:0] hue);
            logic [HUE_W-1:0] h;
            if (op == OP_START)
            begin
                // A start sets the direction from its own hue and shows that hue
                // at once; it leaves the running hue where it was.
                h         = hue % HUE_FULL;
                rotate_up = (h > HUE_PIVOT);
                started   = 1'b1;
                if (value == 0)
                    value = PCT_FULL;
                colour_due.push_back(shade_of(h, '0));
            end
            else if (started)
            begin
                if (rotate_up)
                    running_hue = 9'((32'(running_hue) + HUE_STEP) % HUE_FULL);
                else
                    running_hue = 9'((32'(running_hue) + HUE_WRAP) % HUE_FULL);
                colour_due.push_back(shade_of(running_hue, ramp_period));
            end
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned seen);
            if (want != seen)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, seen);
            end
        endfunction

        // Called for every accepted output beat.
        function void check_colour(logic [OUT_DATA_W-1:0] data);
            colour_t seen, want;
            seen = colour_t'(data[$bits(colour_t)-1:0]);
            if (colour_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, data);
            end
            else
            begin
                want = colour_due.pop_front();
                compare_field("red",       want.red,       seen.red);
                compare_field("green",     want.green,     seen.green);
                compare_field("blue",      want.blue,      seen.blue);
                compare_field("ramp_ms",   want.ramp_ms,   seen.ramp_ms);
                compare_field("shown_hue", want.shown_hue, seen.shown_hue);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [8:0] hue
    logic                  s_axis_tuser;   // [0] op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] red, [15:8] green, [23:16] blue, [39:24] ramp_ms, [48:40] shown_hue
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hue_colour_tracker board = new();
    int                idle_cycles = 0;
    int                burst_left = 0;

    hue_rotation_hsv_to_rgb dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver changes its stall pattern at random intervals, so that
    // back-pressure lands on every stage of the block's work and there are
    // also long stretches with no stall at all.
    always @(negedge clk)
    begin
        static rx_mode_t stall_mode = RX_FREE;
        static int       stall_left = 0;
        if (stall_left == 0)
        begin
            stall_mode = rx_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end
        else
        begin
            stall_left--;
        end
        unique case (stall_mode)
            RX_FREE:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 5) == 0);
            default:   m_axis_tready <= ((stall_left % 4) != 0);
        endcase
    end

    // Output checking and the count of cycles in which nothing moved.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_colour(m_axis_tdata);
    end

    // Watchdog: a run that stops moving for too long has hung.
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("FAIL hue_rotation_hsv_to_rgb");
        $finish;
    end

    // Offers one beat. The sender works in bursts: at the start of each burst it
    // may drop tvalid for a random gap. The task returns at the accepting edge.
    task automatic send_beat(input logic op, input logic [HUE_W-1:0] hue);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-HUE_W){1'b0}}, hue};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_item(op, hue);
    endtask

    // Stops sending, waits for every owed colour and then lets any tick that
    // produces nothing work its way out of the block.
    task automatic hold_until_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (board.colour_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        board.write_register(index, data);
    endtask

    // Writes all three registers and the unused index once the block is idle.
    task automatic configure(input logic [CFG_DATA_W-1:0] sat_data,
                             input logic [CFG_DATA_W-1:0] val_data,
                             input logic [CFG_DATA_W-1:0] ramp_data);
        hold_until_drained();
        write_reg(REG_SAT, sat_data);
        write_reg(REG_VAL, val_data);
        write_reg(REG_RAMP, ramp_data);
        write_reg(REG_SPARE, 16'($urandom));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // A percentage register setting: the ends of the range, values above 100
    // with junk in the unused upper bits, or something ordinary in between.
    function automatic logic [CFG_DATA_W-1:0] pick_percent();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 16'(PCT_FULL);
            2:       return {9'($urandom), 7'($urandom_range(101, 127))};
            default: return 16'($urandom_range(0, 100));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_ramp();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly ordinary hues, sometimes the edges of the colour sectors and
    // sometimes the out-of-range codes that the block must fold back.
    function automatic logic [HUE_W-1:0] pick_hue();
        case ($urandom_range(0, 7))
            0:       return 9'($urandom_range(0, 5) * 60);
            1:       return 9'($urandom_range(360, 511));
            default: return 9'($urandom_range(0, 359));
        endcase
    endfunction

    initial
    begin
        int items;
        int phase_mark;
        bit paused;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_START;
        cfg_we        = 1'b0;
        cfg_index     = REG_SAT;
        cfg_data      = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset register values. Ticks before any start
        // must produce nothing.
        send_beat(OP_TICK, 9'd0);
        send_beat(OP_TICK, 9'h1FF);
        // Hue zero turns the fade downwards, so the first tick wraps to 350.
        send_beat(OP_START, 9'd0);
        send_beat(OP_TICK, 9'd0);
        send_beat(OP_TICK, 9'd0);
        // Just above the pivot the fade turns upwards and wraps through zero.
        send_beat(OP_START, 9'd181);
        send_beat(OP_TICK, 9'd0);
        send_beat(OP_TICK, 9'd0);
        // The pivot itself still counts as downwards.
        send_beat(OP_START, 9'd180);
        send_beat(OP_TICK, 9'd0);
        // Top of the legal range, and codes that have to be folded back.
        send_beat(OP_START, 9'd359);
        send_beat(OP_START, 9'd360);
        send_beat(OP_START, 9'd511);
        // Sector boundaries and the last degree of the first sector.
        send_beat(OP_START, 9'd60);
        send_beat(OP_START, 9'd120);
        send_beat(OP_START, 9'd240);
        send_beat(OP_START, 9'd300);
        send_beat(OP_START, 9'd59);

        // Grey at zero value, which the block reads as full brightness, with
        // the longest ramp period.
        configure(16'd0, 16'd0, 16'hFFFF);
        send_beat(OP_START, 9'd90);
        send_beat(OP_TICK, 9'd0);

        // Every data bit set: saturation and value both beyond 100 percent.
        configure(16'hFFFF, 16'hFFFF, 16'd0);
        send_beat(OP_START, 9'd45);
        send_beat(OP_TICK, 9'd0);
        send_beat(OP_START, 9'd200);
        send_beat(OP_TICK, 9'd0);

        // Random part: mostly a start followed by a run of ticks, with some
        // stray beats of either kind mixed in. The registers change every
        // phase, and once the sender waits for the block to drain completely.
        items      = 0;
        phase_mark = 0;
        paused     = 1'b0;
        while (items < RANDOM_ITEMS)
        begin
            if (items >= phase_mark + PHASE_ITEMS)
            begin
                phase_mark = items;
                configure(pick_percent(), pick_percent(), pick_ramp());
            end
            if (!paused && items >= RANDOM_ITEMS / 2)
            begin
                hold_until_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_beat(1'($urandom), 9'($urandom));
                items++;
            end
            else
            begin
                send_beat(OP_START, pick_hue());
                items++;
                repeat ($urandom_range(1, 24))
                begin
                    send_beat(OP_TICK, 9'($urandom));
                    items++;
                end
            end
        end

        hold_until_drained();
        if (board.errors == 0)
            $display("PASS hue_rotation_hsv_to_rgb");
        else
            $display("FAIL hue_rotation_hsv_to_rgb");
        $finish;
    end

endmodule

@@ hue_rotation_hsv_to_rgb.f @@
+incdir+rtl/core
rtl/core/hrh_pkg.sv
rtl/core/hrh_coef.sv
rtl/core/hrh_lane.sv
rtl/core/hue_rotation_hsv_to_rgb.sv
bench/testbench.sv
